// File: hw/rtl/swk_pkg.sv
// shared types, constants and helper functions for the swerve wheel kinematics block
package swk_pkg;

	localparam int STEP_W = 5;

	localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
	localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [37:0] GAIN_INV_Q30 = 38'sd652032874;
	localparam logic [19:0]        GAIN_INV_Q20 = 20'd636751;
	localparam logic signed [21:0] PI_Q16      = 22'sd205887;
	localparam logic signed [21:0] HALF_PI_Q16 = 22'sd102944;
	localparam logic signed [21:0] TWO_PI_Q16  = 22'sd411774;
	localparam logic [20:0]        GEOM_RESET  = 21'd32768;

	typedef enum logic {
		REG_TRACK_WIDTH = 1'b0,
		REG_WHEEL_BASE  = 1'b1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LINE,
		OP_HOLD,
		OP_SC_INIT,
		OP_ROT_STEP,
		OP_SC_DONE,
		OP_MUL,
		OP_OFFS,
		OP_VEC_INIT,
		OP_VEC_STEP,
		OP_MAG_LO,
		OP_MAG_HI,
		OP_MAG_SUM,
		OP_SPD_LO,
		OP_SPD_HI,
		OP_FIN,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		logic              load;
		dp_op_t            op;
		logic [STEP_W-1:0] step;
		logic [1:0]        wheel;
	} dp_cmd_t;

	typedef struct packed {
		logic action;
		logic rate_zero;
	} dp_stat_t;

	typedef struct packed {
		logic              flip;
		logic signed [17:0] angle;
	} steer_t;

	function automatic logic signed [27:0] atan_q24(input logic [STEP_W-1:0] i);
		logic signed [27:0] r;
		case (i)
			5'd0: r = 28'sd13176795;
			5'd1: r = 28'sd7778716;
			5'd2: r = 28'sd4110060;
			5'd3: r = 28'sd2086331;
			5'd4: r = 28'sd1047214;
			5'd5: r = 28'sd524117;
			5'd6: r = 28'sd262123;
			5'd7: r = 28'sd131069;
			default: r = (i < 5'd24) ? (28'sd1 <<< (5'd24 - i)) : 28'sd0;
		endcase
		return r;
	endfunction

	// wrap to +-pi once, then fold into +-pi/2
	function automatic steer_t steer(input logic signed [21:0] a);
		logic signed [21:0] w;
		steer_t r;
		w = a;
		if (w > PI_Q16) begin
			w = w - TWO_PI_Q16;
		end else if (w < -PI_Q16) begin
			w = w + TWO_PI_Q16;
		end
		r.flip = 1'b0;
		if (w > HALF_PI_Q16) begin
			w = w - PI_Q16;
			r.flip = 1'b1;
		end else if (w < -HALF_PI_Q16) begin
			w = w + PI_Q16;
			r.flip = 1'b1;
		end
		r.angle = w[17:0];
		return r;
	endfunction

endpackage

// File: hw/rtl/swk_if.sv
// request, result and configuration channel interfaces
interface swk_cmd_if import swk_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic signed [20:0] turn_rate;
	logic signed [24:0] line_speed;
	logic signed [18:0] line_heading;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic signed [18:0] pose_heading;
	modport source (output valid, action, center_x, center_y, turn_rate, line_speed,
		line_heading, pose_x, pose_y, pose_heading, input ready);
	modport sink (input valid, action, center_x, center_y, turn_rate, line_speed,
		line_heading, pose_x, pose_y, pose_heading, output ready);
endinterface

interface swk_res_if import swk_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] front_right_speed;
	logic signed [17:0] front_right_angle;
	logic signed [31:0] front_left_speed;
	logic signed [17:0] front_left_angle;
	logic signed [31:0] back_left_speed;
	logic signed [17:0] back_left_angle;
	logic signed [31:0] back_right_speed;
	logic signed [17:0] back_right_angle;
	modport source (output valid, front_right_speed, front_right_angle, front_left_speed,
		front_left_angle, back_left_speed, back_left_angle, back_right_speed,
		back_right_angle, input ready);
	modport sink (input valid, front_right_speed, front_right_angle, front_left_speed,
		front_left_angle, back_left_speed, back_left_angle, back_right_speed,
		back_right_angle, output ready);
endinterface

interface swk_cfg_if import swk_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        index;
	logic [20:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/swk_datapath.sv
// kinematics datapath: shared cordic, shared multiplier, steering fold and result registers
module swk_datapath import swk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [20:0]        track_width,
	input  logic [20:0]        wheel_base,
	input  logic               in_action,
	input  logic signed [31:0] in_center_x,
	input  logic signed [31:0] in_center_y,
	input  logic signed [20:0] in_turn_rate,
	input  logic signed [24:0] in_line_speed,
	input  logic signed [18:0] in_line_heading,
	input  logic signed [31:0] in_pose_x,
	input  logic signed [31:0] in_pose_y,
	input  logic signed [18:0] in_pose_heading,
	output logic signed [31:0] out_speed [4],
	output logic signed [17:0] out_angle [4]
);

	logic               act_q;
	logic signed [31:0] cx_q, cy_q, px_q, py_q;
	logic signed [20:0] w_q;
	logic signed [24:0] v_q;
	logic signed [18:0] th_q, h_q;

	logic signed [37:0] crx_q, cry_q;
	logic signed [27:0] crz_q;
	logic               neg_q, zero_q;
	logic signed [33:0] cos_q, sin_q;
	logic signed [55:0] p_q [4];
	logic signed [55:0] pa_q, pb_q;
	logic signed [25:0] ex_q, ey_q;
	logic [37:0]        mag_q;
	logic signed [31:0] spd_q [4];
	logic signed [17:0] ang_q [4];
	logic signed [17:0] held_q [4];

	logic [20:0]        aw;
	logic signed [33:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [55:0] mul_p;

	logic signed [37:0] shx, shy;
	logic signed [27:0] at;
	logic               pos;

	logic               sa_pos, sb_pos;
	logic signed [56:0] ex_sum, ey_sum;

	logic signed [35:0] dx, dy;
	logic signed [36:0] bx, by;

	logic signed [27:0] hz;
	logic [59:0]        mag_sum;
	logic [60:0]        sp_sum;
	logic [44:0]        sp;
	logic signed [27:0] bz;
	logic signed [19:0] bq;
	steer_t             rot_st, line_st;
	logic signed [31:0] rot_spd;

	assign stat.action    = act_q;
	assign stat.rate_zero = (w_q == 21'sd0);

	assign aw = w_q[20] ? 21'(-w_q) : 21'(w_q);

	always_comb begin
		mul_a = 34'sd0;
		mul_b = 22'sd0;
		case (cmd.op)
			OP_MUL: begin
				mul_a = cmd.step[0] ? sin_q : cos_q;
				mul_b = cmd.step[1] ? signed'({1'b0, wheel_base}) : signed'({1'b0, track_width});
			end
			OP_MAG_LO: begin
				mul_a = signed'({15'd0, crx_q[18:0]});
				mul_b = signed'({2'd0, GAIN_INV_Q20});
			end
			OP_MAG_HI: begin
				mul_a = signed'({15'd0, crx_q[37:19]});
				mul_b = signed'({2'd0, GAIN_INV_Q20});
			end
			OP_SPD_LO: begin
				mul_a = signed'({15'd0, mag_q[18:0]});
				mul_b = signed'({1'b0, aw});
			end
			OP_SPD_HI: begin
				mul_a = signed'({15'd0, mag_q[37:19]});
				mul_b = signed'({1'b0, aw});
			end
			default: begin
				mul_a = 34'sd0;
				mul_b = 22'sd0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// one cordic step, rotation or vectoring
	assign shx = crx_q >>> cmd.step;
	assign shy = cry_q >>> cmd.step;
	assign at  = atan_q24(cmd.step);
	assign pos = (cmd.op == OP_VEC_STEP) ? cry_q[37] : !crz_q[27];

	assign hz = 28'(h_q) <<< 8;

	// wheel corner signs: front right, front left, back left, back right
	assign sa_pos = (cmd.wheel == 2'd0) || (cmd.wheel == 2'd3);
	assign sb_pos = !cmd.wheel[1];
	assign ex_sum = (sa_pos ? 57'(p_q[0]) : -57'(p_q[0]))
		+ (sb_pos ? 57'(p_q[3]) : -57'(p_q[3])) + (57'sd1 <<< 30);
	assign ey_sum = (sa_pos ? -57'(p_q[1]) : 57'(p_q[1]))
		+ (sb_pos ? 57'(p_q[2]) : -57'(p_q[2])) + (57'sd1 <<< 30);

	assign dx = 36'(px_q) - 36'(cx_q) + 36'(ex_q);
	assign dy = 36'(py_q) - 36'(cy_q) + 36'(ey_q);
	assign bx = w_q[20] ? -37'(dy) : 37'(dy);
	assign by = w_q[20] ? 37'(dx) : -37'(dx);

	assign mag_sum = (60'(pb_q) << 19) + 60'(pa_q) + (60'd1 << 19);
	assign sp_sum  = (61'(pb_q) << 19) + 61'(pa_q) + (61'd1 << 15);
	assign sp      = sp_sum[60:16];

	assign bz     = crz_q + 28'sd128;
	assign bq     = zero_q ? 20'sd0 : bz[27:8];
	assign rot_st = steer(22'(bq) - 22'(h_q));

	always_comb begin
		if (rot_st.flip) begin
			rot_spd = (sp > 45'd2147483648) ? 32'sh80000000 : 32'(-sp);
		end else begin
			rot_spd = (sp > 45'd2147483647) ? 32'sh7FFFFFFF : 32'(sp);
		end
	end

	assign line_st = steer(22'(th_q) - 22'(h_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				held_q[k] <= 18'sd0;
			end
		end else if (cmd.op == OP_PUBLISH) begin
			for (int k = 0; k < 4; k++) begin
				held_q[k] <= ang_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			cx_q  <= in_center_x;
			cy_q  <= in_center_y;
			w_q   <= in_turn_rate;
			v_q   <= in_line_speed;
			th_q  <= in_line_heading;
			px_q  <= in_pose_x;
			py_q  <= in_pose_y;
			h_q   <= in_pose_heading;
		end
		case (cmd.op)
			OP_LINE: begin
				for (int k = 0; k < 4; k++) begin
					ang_q[k] <= line_st.angle;
					spd_q[k] <= line_st.flip ? -32'(v_q) : 32'(v_q);
				end
			end
			OP_HOLD: begin
				for (int k = 0; k < 4; k++) begin
					ang_q[k] <= held_q[k];
					spd_q[k] <= 32'sd0;
				end
			end
			OP_SC_INIT: begin
				crx_q <= GAIN_INV_Q30;
				cry_q <= 38'sd0;
				if (hz > HALF_PI_Q24) begin
					crz_q <= hz - PI_Q24;
					neg_q <= 1'b1;
				end else if (hz < -HALF_PI_Q24) begin
					crz_q <= hz + PI_Q24;
					neg_q <= 1'b1;
				end else begin
					crz_q <= hz;
					neg_q <= 1'b0;
				end
			end
			OP_ROT_STEP, OP_VEC_STEP: begin
				crx_q <= pos ? crx_q - shy : crx_q + shy;
				cry_q <= pos ? cry_q + shx : cry_q - shx;
				crz_q <= pos ? crz_q - at : crz_q + at;
			end
			OP_SC_DONE: begin
				cos_q <= neg_q ? -34'(crx_q) : 34'(crx_q);
				sin_q <= neg_q ? -34'(cry_q) : 34'(cry_q);
			end
			OP_MUL: begin
				p_q[cmd.step[1:0]] <= mul_p;
			end
			OP_OFFS: begin
				ex_q <= ex_sum[56:31];
				ey_q <= ey_sum[56:31];
			end
			OP_VEC_INIT: begin
				zero_q <= (dx == 36'sd0) && (dy == 36'sd0);
				if (by < 37'sd0) begin
					if (bx >= 37'sd0) begin
						crx_q <= 38'(bx);
						cry_q <= -38'(by);
						crz_q <= HALF_PI_Q24;
					end else begin
						crx_q <= -38'(bx);
						cry_q <= 38'(by);
						crz_q <= -HALF_PI_Q24;
					end
				end else begin
					crx_q <= 38'(by);
					cry_q <= 38'(bx);
					crz_q <= 28'sd0;
				end
			end
			OP_MAG_LO, OP_SPD_LO: begin
				pa_q <= mul_p;
			end
			OP_MAG_HI, OP_SPD_HI: begin
				pb_q <= mul_p;
			end
			OP_MAG_SUM: begin
				mag_q <= mag_sum[57:20];
			end
			OP_FIN: begin
				ang_q[cmd.wheel] <= rot_st.angle;
				spd_q[cmd.wheel] <= rot_spd;
			end
			OP_PUBLISH: begin
				for (int k = 0; k < 4; k++) begin
					out_speed[k] <= spd_q[k];
					out_angle[k] <= ang_q[k];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hw/rtl/swk_ctrl.sv
// sequencer for the kinematics datapath and the result register handshake
module swk_ctrl import swk_pkg::*; #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_LINE,
		S_HOLD,
		S_SC_INIT,
		S_SC_ITER,
		S_SC_DONE,
		S_MUL,
		S_OFFS,
		S_VEC_INIT,
		S_VEC_ITER,
		S_MAG_LO,
		S_MAG_HI,
		S_MAG_SUM,
		S_SPD_LO,
		S_SPD_HI,
		S_FIN,
		S_PUBLISH
	} state_t;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
	localparam logic [STEP_W-1:0] LAST_MUL  = STEP_W'(3);

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        wheel_q;
	logic              out_valid_q;
	logic              accept;
	logic              out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.load  = accept;
		cmd.step  = step_q;
		cmd.wheel = wheel_q;
		case (state_q)
			S_LINE:     cmd.op = OP_LINE;
			S_HOLD:     cmd.op = OP_HOLD;
			S_SC_INIT:  cmd.op = OP_SC_INIT;
			S_SC_ITER:  cmd.op = OP_ROT_STEP;
			S_SC_DONE:  cmd.op = OP_SC_DONE;
			S_MUL:      cmd.op = OP_MUL;
			S_OFFS:     cmd.op = OP_OFFS;
			S_VEC_INIT: cmd.op = OP_VEC_INIT;
			S_VEC_ITER: cmd.op = OP_VEC_STEP;
			S_MAG_LO:   cmd.op = OP_MAG_LO;
			S_MAG_HI:   cmd.op = OP_MAG_HI;
			S_MAG_SUM:  cmd.op = OP_MAG_SUM;
			S_SPD_LO:   cmd.op = OP_SPD_LO;
			S_SPD_HI:   cmd.op = OP_SPD_HI;
			S_FIN:      cmd.op = OP_FIN;
			S_PUBLISH:  cmd.op = out_free ? OP_PUBLISH : OP_IDLE;
			default:    cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			wheel_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_PUBLISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					step_q  <= '0;
					wheel_q <= '0;
					if (stat.action) begin
						state_q <= S_LINE;
					end else if (stat.rate_zero) begin
						state_q <= S_HOLD;
					end else begin
						state_q <= S_SC_INIT;
					end
				end
				S_LINE, S_HOLD: state_q <= S_PUBLISH;
				S_SC_INIT: state_q <= S_SC_ITER;
				S_SC_ITER: begin
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= S_SC_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_SC_DONE: state_q <= S_MUL;
				S_MUL: begin
					if (step_q == LAST_MUL) begin
						step_q  <= '0;
						state_q <= S_OFFS;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_OFFS: state_q <= S_VEC_INIT;
				S_VEC_INIT: state_q <= S_VEC_ITER;
				S_VEC_ITER: begin
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= S_MAG_LO;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_MAG_LO: state_q <= S_MAG_HI;
				S_MAG_HI: state_q <= S_MAG_SUM;
				S_MAG_SUM: state_q <= S_SPD_LO;
				S_SPD_LO: state_q <= S_SPD_HI;
				S_SPD_HI: state_q <= S_FIN;
				S_FIN: begin
					if (wheel_q == 2'd3) begin
						state_q <= S_PUBLISH;
					end else begin
						wheel_q <= wheel_q + 1'b1;
						state_q <= S_OFFS;
					end
				end
				S_PUBLISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SC_ITER || state_q == S_VEC_ITER) |-> step_q <= LAST_STEP)
		else $error("cordic step counter out of range");
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DISPATCH)
		else $error("accepted request not dispatched");
	a_valid_from_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_PUBLISH))
		else $error("result valid without publish");
	a_wheel_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wheel_q) |-> $past(state_q == S_FIN || state_q == S_DISPATCH))
		else $error("wheel index moved outside wheel loop");
`endif

endmodule

// File: hw/rtl/swerve_wheel_kinematics.sv
// top level of the four-wheel swerve inverse kinematics block
//
//   channel  role    carries
//   command  sink    mode, pose, rotation centre and rate, line speed and heading
//   wheels   source  speed and steering angle for front right, front left,
//                    back left, back right
//   cfg      sink    register index and write data (track width, wheel base)
//
// line mode and zero-rate requests go from dispatch through a line or hold state to publish
// rotation requests use the one shared cordic unit: one sine/cosine pass, then one
// vectoring pass per wheel
// a new request is taken while a finished result waits in the output register
// reset sets both geometry registers to 32768 and the held angles to zero
// cfg is always ready; the user must write it only while the block is idle, the block does not enforce this
module swerve_wheel_kinematics import swk_pkg::*; #(
	parameter int CORDIC_STEPS = 18
) (
	input logic    clk,
	input logic    arst_n,
	swk_cmd_if.sink   command,
	swk_res_if.source wheels,
	swk_cfg_if.sink   cfg
);

	logic [20:0]        track_q, base_q;
	dp_cmd_t            cmd;
	dp_stat_t           stat;
	logic signed [31:0] out_speed [4];
	logic signed [17:0] out_angle [4];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= GEOM_RESET;
			base_q  <= GEOM_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_TRACK_WIDTH: track_q <= cfg.data;
				REG_WHEEL_BASE:  base_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	swk_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (command.valid),
		.in_ready  (command.ready),
		.out_valid (wheels.valid),
		.out_ready (wheels.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	swk_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.track_width     (track_q),
		.wheel_base      (base_q),
		.in_action       (command.action),
		.in_center_x     (command.center_x),
		.in_center_y     (command.center_y),
		.in_turn_rate    (command.turn_rate),
		.in_line_speed   (command.line_speed),
		.in_line_heading (command.line_heading),
		.in_pose_x       (command.pose_x),
		.in_pose_y       (command.pose_y),
		.in_pose_heading (command.pose_heading),
		.out_speed       (out_speed),
		.out_angle       (out_angle)
	);

	assign wheels.front_right_speed = out_speed[0];
	assign wheels.front_right_angle = out_angle[0];
	assign wheels.front_left_speed  = out_speed[1];
	assign wheels.front_left_angle  = out_angle[1];
	assign wheels.back_left_speed   = out_speed[2];
	assign wheels.back_left_angle   = out_angle[2];
	assign wheels.back_right_speed  = out_speed[3];
	assign wheels.back_right_angle  = out_angle[3];

endmodule

// File: bench/tb_top.sv
// testbench for the swerve wheel kinematics block: directed and random requests checked against a local predictor
`timescale 1ns / 100ps
module tb_top;
	import swk_pkg::*;

	localparam int STEPS = 18;
	localparam longint LIMIT = 4000000;

	typedef struct {
		logic [31:0] spd[4];
		logic [17:0] ang[4];
	} wheel_set_t;

	typedef struct {
		bit          action;
		logic [31:0] cx, cy, px, py;
		logic [20:0] rate;
		logic [24:0] lspeed;
		logic [18:0] lhead, phead;
	} req_t;

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	swk_cmd_if command();
	swk_res_if wheels();
	swk_cfg_if cfg();

	swerve_wheel_kinematics #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk(clk), .arst_n(arst_n), .command(command), .wheels(wheels), .cfg(cfg)
	);

	wheel_set_t expected_sets[$];
	longint track_w = 32768, base_w = 32768;
	longint held[4];
	int errors = 0;
	int burst_left = 0;
	longint cycles = 0;
	bit stall_mode = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic longint asr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint rnd(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint atan_tab(input int i);
		longint t[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069};
		if (i < 8) return t[i];
		if (i >= 24) return 0;
		return longint'(1) << (24 - i);
	endfunction

	function automatic longint fold_angle(input longint a, output bit flip);
		if (a > 205887) a -= 411774;
		else if (a < -205887) a += 411774;
		flip = 0;
		if (a > 102944) begin
			a -= 205887;
			flip = 1;
		end else if (a < -102944) begin
			a += 205887;
			flip = 1;
		end
		return a;
	endfunction

	task automatic heading_sin_cos(input longint h, output longint c, output longint s);
		longint z, x, y, t;
		bit neg;
		z = h * 256;
		x = 652032874;
		y = 0;
		neg = 0;
		if (z > 26353589) begin
			z -= 52707179;
			neg = 1;
		end else if (z < -26353589) begin
			z += 52707179;
			neg = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				t = x - asr(y, i); y = y + asr(x, i); x = t; z -= atan_tab(i);
			end else begin
				t = x + asr(y, i); y = y - asr(x, i); x = t; z += atan_tab(i);
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	task automatic wheel_bearing(input longint bx, input longint by, output longint b,
			output longint mag);
		longint re, im, z, t;
		re = by;
		im = bx;
		z = 0;
		if (re == 0 && im == 0) begin
			mag = 0;
			b = 0;
			return;
		end
		if (re < 0) begin
			if (im >= 0) begin
				t = im; im = -re; re = t; z = 26353589;
			end else begin
				t = -im; im = re; re = t; z = -26353589;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			if (im >= 0) begin
				t = re + asr(im, i); im = im - asr(re, i); re = t; z += atan_tab(i);
			end else begin
				t = re - asr(im, i); im = im + asr(re, i); re = t; z -= atan_tab(i);
			end
		end
		mag = rnd(re * 636751, 20);
		b = rnd(z, 8);
	endtask

	task automatic predict_wheels(input req_t r);
		wheel_set_t e;
		longint sa[4] = '{1, -1, -1, 1};
		longint sb[4] = '{1, 1, -1, -1};
		longint w, v, th, h, a, c, s, aw, ex, ey, dx, dy, mag, b, sp;
		bit flip;
		w = longint'($signed(r.rate));
		v = longint'($signed(r.lspeed));
		th = longint'($signed(r.lhead));
		h = longint'($signed(r.phead));
		if (r.action) begin
			a = fold_angle(th - h, flip);
			for (int k = 0; k < 4; k++) begin
				e.ang[k] = a[17:0];
				sp = flip ? -v : v;
				e.spd[k] = sp[31:0];
				held[k] = a;
			end
		end else if (w == 0) begin
			for (int k = 0; k < 4; k++) begin
				e.ang[k] = held[k][17:0];
				e.spd[k] = 0;
			end
		end else begin
			aw = w < 0 ? -w : w;
			heading_sin_cos(h, c, s);
			for (int k = 0; k < 4; k++) begin
				ex = rnd(sa[k] * track_w * c + sb[k] * base_w * s, 31);
				ey = rnd(-sa[k] * track_w * s + sb[k] * base_w * c, 31);
				dx = longint'($signed(r.px)) - longint'($signed(r.cx)) + ex;
				dy = longint'($signed(r.py)) - longint'($signed(r.cy)) + ey;
				if (w > 0) wheel_bearing(dy, -dx, b, mag);
				else wheel_bearing(-dy, dx, b, mag);
				a = fold_angle(b - h, flip);
				sp = rnd(mag * aw, 16);
				if (flip) sp = -sp;
				if (sp > 64'sd2147483647) sp = 64'sd2147483647;
				if (sp < -64'sd2147483648) sp = -64'sd2147483648;
				e.ang[k] = a[17:0];
				e.spd[k] = sp[31:0];
				held[k] = a;
			end
		end
		expected_sets.push_back(e);
	endtask

	task automatic send_request(input req_t r);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 200) : 0) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		command.valid <= 1;
		command.action <= r.action;
		command.center_x <= r.cx;
		command.center_y <= r.cy;
		command.turn_rate <= r.rate;
		command.line_speed <= r.lspeed;
		command.line_heading <= r.lhead;
		command.pose_x <= r.px;
		command.pose_y <= r.py;
		command.pose_heading <= r.phead;
		do @(posedge clk); while (!command.ready);
		predict_wheels(r);
		command.valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_sets.size() != 0) @(posedge clk);
		repeat (5 * STEPS + 60) @(posedge clk);
	endtask

	task automatic write_geometry(input cfg_reg_t idx, input logic [20:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_TRACK_WIDTH) track_w = val;
		else base_w = val;
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [18:0] rand_heading();
		int unsigned m = $urandom_range(0, 7);
		if (m == 0) return 19'h3ffff;
		if (m == 1) return 19'h40000;
		if (m < 4) return 19'($urandom());
		return 19'($signed($urandom_range(0, 411774)) - 205887);
	endfunction

	function automatic logic [31:0] rand_pos();
		int unsigned m = $urandom_range(0, 9);
		if (m == 0) return $urandom();
		if (m == 1) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		return 32'($signed($urandom_range(0, 2000000)) - 1000000);
	endfunction

	function automatic req_t rand_request();
		req_t r;
		r.action = $urandom_range(0, 2) == 0;
		r.cx = rand_pos();
		r.cy = rand_pos();
		r.px = $urandom_range(0, 4) == 0 ? r.cx : rand_pos();
		r.py = $urandom_range(0, 4) == 0 ? r.cy : rand_pos();
		case ($urandom_range(0, 9))
			0: r.rate = 0;
			1: r.rate = $urandom_range(0, 1) ? 21'sd1048575 : -21'sd1048575;
			default: r.rate = 21'($signed($urandom_range(0, 2097150)) - 1048575);
		endcase
		if ($urandom_range(0, 5) == 0) r.rate = 21'($urandom());
		r.lspeed = $urandom_range(0, 5) == 0 ? 25'($urandom()) :
			25'($signed($urandom_range(0, 33554430)) - 16777215);
		r.lhead = rand_heading();
		r.phead = rand_heading();
		return r;
	endfunction

	function automatic req_t line_request(input logic [18:0] lh, input logic [18:0] ph,
			input logic [24:0] v);
		req_t r = rand_request();
		r.action = 1;
		r.lhead = lh;
		r.phead = ph;
		r.lspeed = v;
		return r;
	endfunction

	function automatic req_t turn_request(input logic [31:0] cx, input logic [31:0] cy,
			input logic [20:0] w, input logic [18:0] ph);
		req_t r = rand_request();
		r.action = 0;
		r.cx = cx;
		r.cy = cy;
		r.px = 0;
		r.py = 0;
		r.rate = w;
		r.phead = ph;
		return r;
	endfunction

	task automatic test_line_mode();
		send_request(line_request(19'sd0, 19'sd0, 25'sd16777215));
		send_request(line_request(19'sd205887, -19'sd205887, -25'sd16777215));
		send_request(line_request(19'sd102945, 19'sd0, 25'sd65536));
		send_request(line_request(-19'sd102945, 19'sd0, 25'sd65536));
		send_request(line_request(19'h3ffff, 19'h40000, 25'h1000000));
		send_request(line_request(19'h40000, 19'h3ffff, 25'h0ffffff));
	endtask

	task automatic test_rotation();
		send_request(turn_request(32'sd655360, 0, 21'sd65536, 0));
		send_request(turn_request(0, 32'sd655360, -21'sd65536, 19'sd205887));
		send_request(turn_request(0, -32'sd655360, 21'sd65536, 0));
		send_request(turn_request(32'sd16384, 32'sd16384, 21'sd1048575, 19'sd51471));
		send_request(turn_request(32'h80000000, 32'h7fffffff, 21'sd1048575, 0));
		send_request(turn_request(32'h7fffffff, 32'h80000000, -21'sd1048575,
			-19'sd205887));
		send_request(turn_request(0, 0, 21'h100000, 19'h3ffff));
	endtask

	task automatic test_zero_rate();
		send_request(turn_request(32'sd100, 32'sd100, 0, 19'sd1000));
		send_request(line_request(19'sd5000, 0, 25'sd7));
		send_request(turn_request(32'sd100, 32'sd100, 0, 19'sd1000));
	endtask

	task automatic test_geometry();
		logic [20:0] vals[4] = '{21'd0, 21'd1048576, 21'd1, 21'h1fffff};
		foreach (vals[i]) begin
			drain();
			write_geometry(REG_TRACK_WIDTH, vals[i]);
			write_geometry(REG_WHEEL_BASE, vals[(i + 1) % 4]);
			send_request(turn_request(0, 0, 21'sd65536, 0));
			repeat (40) send_request(rand_request());
		end
		drain();
		write_geometry(REG_TRACK_WIDTH, 21'd32768);
		write_geometry(REG_WHEEL_BASE, 21'd49152);
	endtask

	task automatic test_random();
		for (int n = 0; n < 1150; n++) begin
			if (n == 500) drain();
			send_request(rand_request());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
			wheels.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		wheel_set_t e;
		logic [31:0] gs[4];
		logic [17:0] ga[4];
		if (arst_n && wheels.valid && wheels.ready) begin
			gs = '{wheels.front_right_speed, wheels.front_left_speed,
				wheels.back_left_speed, wheels.back_right_speed};
			ga = '{wheels.front_right_angle, wheels.front_left_angle,
				wheels.back_left_angle, wheels.back_right_angle};
			if (expected_sets.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				e = expected_sets.pop_front();
				for (int k = 0; k < 4; k++) begin
					if (gs[k] !== e.spd[k])
						report($sformatf("wheel %0d speed", k), $signed(gs[k]),
							$signed(e.spd[k]));
					if (ga[k] !== e.ang[k])
						report($sformatf("wheel %0d angle", k), $signed(ga[k]),
							$signed(e.ang[k]));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		held = '{0, 0, 0, 0};
		command.valid = 0;
		command.action = 0;
		command.center_x = 0;
		command.center_y = 0;
		command.turn_rate = 0;
		command.line_speed = 0;
		command.line_heading = 0;
		command.pose_x = 0;
		command.pose_y = 0;
		command.pose_heading = 0;
		wheels.ready = 0;
		cfg.valid = 0;
		cfg.index = REG_TRACK_WIDTH;
		cfg.data = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_line_mode();
		test_rotation();
		test_zero_rate();
		test_geometry();
		test_random();
		drain();
		if (errors == 0 && expected_sets.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
